>>> rtl/core/tcr_pkg.sv
// Shared types and constants for the text cell renderer.
package tcr_pkg;

  localparam int STORE_AW    = 10;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int ADDR_W      = 15;
  localparam int CELL_BYTES  = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int CFG_IDX_W   = 3;

  localparam logic       OP_FONT_WRITE = 1'b0;
  localparam logic       OP_CHAR       = 1'b1;
  localparam logic [7:0] CODE_NONE     = 8'h00;
  localparam logic [7:0] CODE_INVERSE  = 8'h01;
  localparam logic [15:0] INVERSE_MASK = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_PAL_ZERO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_THREE = 3'd3;

  typedef logic [3:0] color_t;
  typedef color_t [3:0] palette_t;

  localparam palette_t PALETTE_RESET = {4'd3, 4'd3, 4'd3, 4'd0};

  typedef struct packed {
    logic                is_draw;
    logic [STORE_AW-1:0] mem_addr;
    logic [15:0]         bits;
    logic                inv;
    logic [ADDR_W-1:0]   base;
  } q_entry_t;

endpackage

>>> rtl/core/tcr_front.sv
// Front end: accepts items, tracks the cursor and classifies each item.
module tcr_front #(
  parameter int GLYPH_COUNT  = 128,
  parameter int GRID_COLUMNS = 40,
  parameter int GRID_ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [6:0]        in_glyph_index,
  input  logic [2:0]        in_glyph_row,
  input  logic [15:0]       in_glyph_bits,
  input  logic [7:0]        in_char_code,
  input  logic              in_string_start,
  input  logic [7:0]        in_start_column,
  input  logic [7:0]        in_start_row,
  input  logic              q_full,
  output logic              q_push,
  output tcr_pkg::q_entry_t q_entry
);
  import tcr_pkg::*;

  localparam int          ROW_BYTES = 8 * GRID_COLUMNS * CELL_BYTES;
  localparam logic [8:0]  COLS_LIM  = 9'(GRID_COLUMNS);
  localparam logic [8:0]  ROWS_LIM  = 9'(GRID_ROWS);
  localparam logic [8:0]  GLYPH_LIM = 9'(GLYPH_COUNT);

  logic [7:0]  col_r, col_nxt;
  logic [7:0]  row_r, row_nxt;
  logic        inv_r, inv_nxt;
  logic        halt_r, halt_nxt;
  logic        accept;
  logic [7:0]  col0, row0, col1, row1;
  logic        inv0, halt0, wrap;
  logic [6:0]  glyph;
  logic [23:0] base_full;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    col0  = in_string_start ? in_start_column : col_r;
    row0  = in_string_start ? in_start_row : row_r;
    inv0  = in_string_start ? 1'b0 : inv_r;
    halt0 = in_string_start ? 1'b0 : halt_r;
    wrap  = {1'b0, col0} >= COLS_LIM;
    col1  = wrap ? 8'd0 : col0;
    row1  = (wrap && row0 != 8'hFF) ? row0 + 8'd1 : row0;
    glyph = ({1'b0, in_char_code} >= GLYPH_LIM) ? 7'd0 : in_char_code[6:0];
    base_full = 24'(row1) * 24'(ROW_BYTES) + 24'({col1, 2'b00});

    col_nxt  = col_r;
    row_nxt  = row_r;
    inv_nxt  = inv_r;
    halt_nxt = halt_r;
    q_push   = 1'b0;
    q_entry  = '0;

    if (accept) begin
      if (in_operation == OP_FONT_WRITE) begin
        q_push           = 1'b1;
        q_entry.is_draw  = 1'b0;
        q_entry.mem_addr = {in_glyph_index, in_glyph_row};
        q_entry.bits     = in_glyph_bits;
      end else begin
        col_nxt  = col0;
        row_nxt  = row0;
        inv_nxt  = inv0;
        halt_nxt = halt0;
        if (in_char_code == CODE_NONE || halt0) begin
          // drop
        end else if (in_char_code == CODE_INVERSE) begin
          inv_nxt = ~inv0;
        end else begin
          col_nxt = col1;
          row_nxt = row1;
          if ({1'b0, row1} >= ROWS_LIM) begin
            halt_nxt = 1'b1;
          end else begin
            col_nxt          = col1 + 8'd1;
            q_push           = 1'b1;
            q_entry.is_draw  = 1'b1;
            q_entry.mem_addr = {glyph, 3'b000};
            q_entry.inv      = inv0;
            q_entry.base     = base_full[ADDR_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      inv_r  <= 1'b0;
      halt_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      inv_r  <= inv_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

>>> rtl/core/tcr_queue.sv
// Short work queue between the front and back ends.
module tcr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tcr_pkg::q_entry_t push_entry,
  input  logic              pop,
  output tcr_pkg::q_entry_t head,
  output logic              full,
  output logic              empty
);
  import tcr_pkg::*;

  q_entry_t            slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  assign head  = slot_r[rd_ptr_r];
  assign full  = count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign empty = count_r == '0;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/core/tcr_back.sv
// Back end: font memory, row sequencer, palette expansion and output register.
module tcr_back #(
  parameter int GRID_COLUMNS = 40
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tcr_pkg::q_entry_t         head,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  tcr_pkg::palette_t         palette,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [tcr_pkg::ADDR_W-1:0] out_byte_address,
  output logic [31:0]               out_pixel_word,
  output logic                      out_last_row
);
  import tcr_pkg::*;

  localparam logic [ADDR_W-1:0] LINE_BYTES = ADDR_W'(GRID_COLUMNS * CELL_BYTES);

  logic [15:0] font_mem [STORE_DEPTH];
  logic [15:0] rd_data_r;

  logic              busy_r, busy_nxt;
  logic [2:0]        row_r, row_nxt;
  logic [6:0]        glyph_r, glyph_nxt;
  logic              inv_r, inv_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;

  logic              a_valid_r, a_valid_nxt;
  logic [ADDR_W-1:0] a_addr_r;
  logic              a_last_r, a_inv_r;

  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [31:0]       out_word_r;
  logic              out_last_r;

  logic              b_ready, a_move, can_issue, issue, start_draw, font_wr;
  logic [STORE_AW-1:0] rd_addr;
  logic [ADDR_W-1:0] issue_addr;
  logic              issue_inv, issue_last;
  logic [15:0]       bits;
  logic [31:0]       word;

  assign b_ready    = !out_valid_r || !out_stall;
  assign a_move     = a_valid_r && b_ready;
  assign can_issue  = !a_valid_r || a_move;
  assign start_draw = !busy_r && !q_empty && head.is_draw && can_issue;
  assign font_wr    = !busy_r && !q_empty && !head.is_draw;
  assign issue      = busy_r ? can_issue : start_draw;
  assign q_pop      = start_draw || font_wr;

  assign rd_addr    = busy_r ? {glyph_r, row_r} : {head.mem_addr[STORE_AW-1:3], 3'b000};
  assign issue_addr = busy_r ? addr_r : head.base;
  assign issue_inv  = busy_r ? inv_r : head.inv;
  assign issue_last = busy_r && row_r == 3'd7;

  always_ff @(posedge clk) begin
    if (font_wr) begin
      font_mem[head.mem_addr] <= head.bits;
    end
    if (issue) begin
      rd_data_r <= font_mem[rd_addr];
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    row_nxt   = row_r;
    glyph_nxt = glyph_r;
    inv_nxt   = inv_r;
    addr_nxt  = addr_r;
    if (start_draw) begin
      busy_nxt  = 1'b1;
      row_nxt   = 3'd1;
      glyph_nxt = head.mem_addr[STORE_AW-1:3];
      inv_nxt   = head.inv;
      addr_nxt  = head.base + LINE_BYTES;
    end else if (busy_r && issue) begin
      row_nxt  = row_r + 3'd1;
      addr_nxt = addr_r + LINE_BYTES;
      if (row_r == 3'd7) begin
        busy_nxt = 1'b0;
      end
    end
    a_valid_nxt = issue || (a_valid_r && !a_move);
  end

  always_comb begin
    bits = rd_data_r ^ (a_inv_r ? INVERSE_MASK : 16'h0000);
    for (int p = 0; p < 8; p++) begin
      word[31-4*p -: 4] = palette[bits[15-2*p -: 2]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      row_r       <= '0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      row_r     <= row_nxt;
      a_valid_r <= a_valid_nxt;
      if (b_ready) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    glyph_r <= glyph_nxt;
    inv_r   <= inv_nxt;
    addr_r  <= addr_nxt;
    if (issue) begin
      a_addr_r <= issue_addr;
      a_last_r <= issue_last;
      a_inv_r  <= issue_inv;
    end
    if (a_move) begin
      out_addr_r <= a_addr_r;
      out_word_r <= word;
      out_last_r <= a_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_address = out_addr_r;
  assign out_pixel_word   = out_word_r;
  assign out_last_row     = out_last_r;

endmodule

>>> rtl/core/text_cell_render_4bpp_core.sv
// Text cell renderer top level: palette registers, front end, queue and back end.
//
// Input channel (in_*): font-write items store one 16-bit glyph row; character
// items draw a glyph at the text cursor, or load the cursor, toggle inverse or
// are dropped. Result channel (out_*): one framebuffer row word per glyph row,
// eight per drawn character, out_last_row marking the eighth.
// The front end takes one item per cycle into a four-entry queue; in_stall rises
// only while that queue is full. The back end drains it: a font write is stored
// as it is popped; a character holds the back end busy until its eighth row read
// issues, one row word per cycle while the output is not stalled, through the
// single read port of the 1024 x 16 font memory. out_valid rises with the first
// row word once the character has passed the queue, read and output registers.
// A stalled result holds in the output register; one row may wait behind it in
// the read stage, then the back end halts and the queue fills.
// Reset (rst_n low, synchronous) clears the cursor, inverse and halted flags,
// the queue and all valid flags and loads the palette with 0, 3, 3, 3. The font
// memory is not cleared; a glyph row must be written before it is drawn.
// The user must write the palette (cfg_index 0 to 3) only if idle; not enforced.
module text_cell_render_4bpp_core #(
  parameter int GLYPH_COUNT  = 128,
  parameter int GRID_COLUMNS = 40,
  parameter int GRID_ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [3:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [6:0]                    in_glyph_index,
  input  logic [2:0]                    in_glyph_row,
  input  logic [15:0]                   in_glyph_bits,
  input  logic [7:0]                    in_char_code,
  input  logic                          in_string_start,
  input  logic [7:0]                    in_start_column,
  input  logic [7:0]                    in_start_row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcr_pkg::ADDR_W-1:0]    out_byte_address,
  output logic [31:0]                   out_pixel_word,
  output logic                          out_last_row
);
  import tcr_pkg::*;

  palette_t palette_r;
  q_entry_t push_entry, head;
  logic     q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_r <= PALETTE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAL_ZERO:  palette_r[0] <= cfg_data;
        CFG_PAL_ONE:   palette_r[1] <= cfg_data;
        CFG_PAL_TWO:   palette_r[2] <= cfg_data;
        CFG_PAL_THREE: palette_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  tcr_front #(
    .GLYPH_COUNT  (GLYPH_COUNT),
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_glyph_index  (in_glyph_index),
    .in_glyph_row    (in_glyph_row),
    .in_glyph_bits   (in_glyph_bits),
    .in_char_code    (in_char_code),
    .in_string_start (in_string_start),
    .in_start_column (in_start_column),
    .in_start_row    (in_start_row),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (push_entry)
  );

  tcr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  tcr_back #(
    .GRID_COLUMNS (GRID_COLUMNS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .palette          (palette_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_address (out_byte_address),
    .out_pixel_word   (out_pixel_word),
    .out_last_row     (out_last_row)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall && !q_pop) |=> in_stall)
    else $error("queue drained without a pop");

endmodule
